FILE: hdl/slau_pkg.sv
// shared constants, types and saturation helpers for the sparse adam update block
`default_nettype none

package slau_pkg;

    // sizes of the weight store and the batch limit
    localparam int WEIGHT_COUNT = 65536;
    localparam int IDX_W        = $clog2(WEIGHT_COUNT);
    localparam int CNT_W        = IDX_W + 1;
    localparam int MAX_BATCH    = 4096;

    // port widths
    localparam int FIELD_IDX_W = 16;
    localparam int BS_W        = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 31;

    // fixed point one in q16.16
    localparam logic [16:0] ONE_Q = 17'd65536;

    localparam logic signed [65:0] S66_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S66_MIN = -66'sd2147483648;

    // item opcodes
    typedef enum logic [1:0] {
        OP_FEATURE = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_BATCH   = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 3'd4;

    // result kinds
    localparam logic RES_READ  = 1'b0;
    localparam logic RES_BATCH = 1'b1;

    // one row of the weight store
    typedef struct packed {
        logic               seen;
        logic        [31:0] v;
        logic signed [31:0] m;
        logic signed [31:0] g;
        logic signed [31:0] w;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // sequencer steps
    typedef enum logic [5:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_LATCH,
        ST_F_MUL, ST_F_DIV, ST_F_WAIT,
        ST_S_DIV, ST_S_WAIT,
        ST_L2_MUL, ST_L2_DIV, ST_L2_WAIT,
        ST_WRITE,
        ST_B_LOAD, ST_B_SQRT, ST_B_SQWAIT, ST_B_AMUL, ST_B_ADIV, ST_B_AWAIT,
        ST_B_NEXT, ST_B_FETCH, ST_B_ENTRY,
        ST_U_GG, ST_U_M1, ST_U_M2, ST_U_V1, ST_U_V2, ST_U_V3, ST_U_V4,
        ST_U_SQWAIT, ST_U_WMUL, ST_U_WDIV, ST_U_WWAIT, ST_U_WRITE,
        ST_B_P1, ST_B_P2, ST_B_P3,
        ST_POST
    } state_t;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > S66_MAX)
            r = 32'sh7FFF_FFFF;
        else if (x < S66_MIN)
            r = 32'sh8000_0000;
        else
            r = $signed(x[31:0]);
        return r;
    endfunction

    // saturating add of two q16.16 values
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat32(66'(a) + 66'(b));
    endfunction

    // signed quotient from sign and magnitude, clamped to 32 bits
    function automatic logic signed [31:0] sat_quo(input logic neg, input logic [63:0] q);
        logic signed [31:0] r;
        if (neg)
            r = (q > 64'd2147483648) ? 32'sh8000_0000 : -$signed(q[31:0]);
        else
            r = (q > 64'd2147483647) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
        return r;
    endfunction

    // divide by 2^16 with truncation toward zero
    function automatic logic signed [65:0] trunc16(input logic signed [65:0] x);
        logic signed [65:0] r;
        if (x < 66'sd0)
            r = (x + 66'sd65535) >>> 16;
        else
            r = x >>> 16;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/slau_ram.sv
// generic single write port ram with registered read
`default_nettype none

module slau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hdl/sparse_logreg_adam_update_top.sv
// sparse logistic regression trainer with adam update, top level
// Usage: items enter on in_valid/in_ready with an opcode. A feature item adds
// its gradient (and the l2 term on first sight in a batch), a sample end item
// adds the bias gradient, a batch end item updates every touched weight and
// answers with the batch number, a read item answers with one weight.
// Results leave on out_valid/out_ready through an output register; the block
// takes the next item while a result waits, and holds before posting a second
// result until the first one is taken.
// Items are handled one at a time by a sequencer around one 33x33 multiplier,
// a one-bit-per-cycle divider and a two-bit-per-cycle square root.
// Configuration writes take effect at once; the user must make them while
// idle, as the block itself does not enforce it.
// Reset: a clearing pass writes zero to all 65536 rows of the weight store,
// one row per cycle; in_ready stays low until the pass is done.
`default_nettype none

module sparse_logreg_adam_update_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [slau_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slau_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       opcode,
    input  logic [slau_pkg::FIELD_IDX_W-1:0] feature_index,
    input  logic signed [31:0]               feature_value,
    input  logic                             label_bit,
    input  logic [16:0]                      predicted_score,
    input  logic [slau_pkg::BS_W-1:0]        batch_size,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             result_kind,
    output logic [slau_pkg::FIELD_IDX_W-1:0] weight_index,
    output logic signed [31:0]               weight_value
);

    import slau_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic [16:0] alpha_reg, beta1_reg, beta2_reg, eps_reg;
    logic [30:0] lambda_reg;

    // current item
    op_t                    op_reg;
    logic [FIELD_IDX_W-1:0] idx_reg;
    logic                   idx_ok_reg;
    logic signed [31:0]     val_reg;
    logic signed [17:0]     err_reg;
    logic [BS_W-1:0]        bs_reg;
    logic signed [18:0]     err_full;
    logic [BS_W-1:0]        bs_eff;

    // sequencer state
    logic [IDX_W-1:0]   clr_reg;
    logic [IDX_W-1:0]   cur_idx_reg;
    logic [CNT_W-1:0]   tc_reg, k_reg;
    logic [16:0]        p1_reg, p2_reg;
    logic               loaded_reg;
    logic [31:0]        batch_cnt_reg;
    entry_t             ent_reg;
    logic signed [31:0] step_reg;
    logic signed [65:0] acc_reg;
    logic [46:0]        gg_reg;
    logic [24:0]        den_reg;

    // output register
    logic                   out_valid_reg;
    logic                   res_kind_reg;
    logic [FIELD_IDX_W-1:0] res_idx_reg;
    logic signed [31:0]     res_val_reg;

    // multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    // divider
    logic               dv_start;
    logic signed [63:0] dv_num;
    logic [28:0]        dv_den;
    logic [63:0]        dv_quo_reg;
    logic [28:0]        dv_rem_reg, dv_den_reg;
    logic [6:0]         dv_cnt_reg;
    logic               dv_busy_reg, dv_neg_reg;
    logic [29:0]        dv_trial;
    logic               dv_ge;
    logic signed [31:0] dv_q;

    // square root
    logic        sq_start;
    logic [47:0] sq_in;
    logic [47:0] sq_x_reg;
    logic [25:0] sq_rem_reg;
    logic [23:0] sq_root_reg;
    logic [4:0]  sq_cnt_reg;
    logic        sq_busy_reg;
    logic [27:0] sq_r2, sq_trial;
    logic        sq_ge;

    // memories
    logic             ent_we, tl_we;
    logic [IDX_W-1:0] ent_wr_addr, ent_rd_addr, tl_wr_addr, tl_rd_addr;
    entry_t           ent_wr_data, ent_rd_data;
    logic [IDX_W-1:0] tl_wr_data, tl_rd_data;
    logic [ENTRY_W-1:0] ent_rd_bits;

    // derived values
    logic [16:0]        b1, b2, cb1, cb2, c1, c2;
    logic               mark_ok;
    logic signed [32:0] g33, ag33;
    logic signed [65:0] m_sum, v_sum, v_shift;
    logic signed [31:0] m_new;
    logic [31:0]        vn;

    // clamped betas and bias correction terms
    assign b1  = (beta1_reg > ONE_Q) ? ONE_Q : beta1_reg;
    assign b2  = (beta2_reg > ONE_Q) ? ONE_Q : beta2_reg;
    assign cb1 = ONE_Q - b1;
    assign cb2 = ONE_Q - b2;
    assign c1  = (p1_reg == ONE_Q) ? 17'd1 : ONE_Q - p1_reg;
    assign c2  = ONE_Q - p2_reg;

    // input item decode
    assign err_full = $signed({2'b00, label_bit, 16'h0000}) - $signed({2'b00, predicted_score});
    always_comb
    begin
        if (batch_size == '0)
            bs_eff = BS_W'(1);
        else if (batch_size > BS_W'(MAX_BATCH))
            bs_eff = BS_W'(MAX_BATCH);
        else
            bs_eff = batch_size;
    end

    assign mark_ok = !ent_reg.seen && (tc_reg < CNT_W'(WEIGHT_COUNT));
    assign g33     = 33'(ent_reg.g);
    assign ag33    = (g33 < 33'sd0) ? -g33 : g33;

    // moment arithmetic
    assign m_sum   = acc_reg + prod_reg;
    assign m_new   = sat32(trunc16(m_sum));
    assign v_sum   = acc_reg + prod_reg;
    assign v_shift = v_sum >>> 16;
    assign vn      = (v_shift > S66_MAX) ? 32'h7FFF_FFFF : v_shift[31:0];

    // shared multiplier
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // shared divider, one quotient bit per cycle
    assign dv_trial = {dv_rem_reg, dv_quo_reg[63]};
    assign dv_ge    = dv_trial >= {1'b0, dv_den_reg};
    assign dv_q     = sat_quo(dv_neg_reg, dv_quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_cnt_reg  <= '0;
        end
        else if (dv_start)
        begin
            dv_busy_reg <= 1'b1;
            dv_cnt_reg  <= 7'd64;
        end
        else if (dv_busy_reg)
        begin
            dv_busy_reg <= dv_cnt_reg != 7'd1;
            dv_cnt_reg  <= dv_cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_start)
        begin
            dv_neg_reg <= dv_num[63];
            dv_quo_reg <= dv_num[63] ? 64'(-dv_num) : 64'(dv_num);
            dv_rem_reg <= '0;
            dv_den_reg <= dv_den;
        end
        else if (dv_busy_reg)
        begin
            dv_rem_reg <= dv_ge ? 29'(dv_trial - {1'b0, dv_den_reg}) : dv_trial[28:0];
            dv_quo_reg <= {dv_quo_reg[62:0], dv_ge};
        end
    end

    // shared square root, two input bits per cycle
    assign sq_r2    = {sq_rem_reg, sq_x_reg[47:46]};
    assign sq_trial = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge    = sq_r2 >= sq_trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end
        else if (sq_start)
        begin
            sq_busy_reg <= 1'b1;
            sq_cnt_reg  <= 5'd24;
        end
        else if (sq_busy_reg)
        begin
            sq_busy_reg <= sq_cnt_reg != 5'd1;
            sq_cnt_reg  <= sq_cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_start)
        begin
            sq_x_reg    <= sq_in;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (sq_busy_reg)
        begin
            sq_x_reg    <= {sq_x_reg[45:0], 2'b00};
            sq_rem_reg  <= sq_ge ? 26'(sq_r2 - sq_trial) : sq_r2[25:0];
            sq_root_reg <= {sq_root_reg[22:0], sq_ge};
        end
    end

    // weight store: weight, gradient, moments and seen flag per row
    slau_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WEIGHT_COUNT)
    ) u_entry_ram (
        .clk     (clk),
        .we      (ent_we),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_bits)
    );
    assign ent_rd_data = entry_t'(ent_rd_bits);

    // list of rows touched in the current batch
    slau_ram #(
        .WIDTH (IDX_W),
        .DEPTH (WEIGHT_COUNT)
    ) u_touched_ram (
        .clk     (clk),
        .we      (tl_we),
        .wr_addr (tl_wr_addr),
        .wr_data (tl_wr_data),
        .rd_addr (tl_rd_addr),
        .rd_data (tl_rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= 17'd66;
            beta1_reg  <= 17'd58982;
            beta2_reg  <= 17'd65470;
            lambda_reg <= '0;
            eps_reg    <= 17'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALPHA: alpha_reg  <= cfg_data[16:0];
                CFG_BETA1: beta1_reg  <= cfg_data[16:0];
                CFG_BETA2: beta2_reg  <= cfg_data[16:0];
                CFG_L2:    lambda_reg <= cfg_data;
                CFG_EPS:   eps_reg    <= cfg_data[16:0];
                default:   ;
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state and unit control
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        dv_start    = 1'b0;
        dv_num      = '0;
        dv_den      = '0;
        sq_start    = 1'b0;
        sq_in       = '0;
        ent_we      = 1'b0;
        ent_wr_addr = cur_idx_reg;
        ent_wr_data = ent_reg;
        ent_rd_addr = cur_idx_reg;
        tl_we       = 1'b0;
        tl_wr_addr  = tc_reg[IDX_W-1:0];
        tl_wr_data  = cur_idx_reg;
        tl_rd_addr  = k_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                ent_we      = 1'b1;
                ent_wr_addr = clr_reg;
                ent_wr_data = '0;
                if (clr_reg == IDX_W'(WEIGHT_COUNT - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_LATCH;
            ST_LATCH:
            begin
                unique case (op_reg)
                    OP_FEATURE: state_next = idx_ok_reg ? ST_F_MUL : ST_IDLE;
                    OP_SAMPLE:  state_next = ST_S_DIV;
                    OP_BATCH:   state_next = ST_L2_MUL;
                    OP_READ:    state_next = ST_POST;
                    default:    state_next = ST_IDLE;
                endcase
            end
            // feature gradient err*value/(bs*2^16)
            ST_F_MUL:
            begin
                mul_a      = 33'(err_reg);
                mul_b      = 33'(val_reg);
                state_next = ST_F_DIV;
            end
            ST_F_DIV:
            begin
                dv_start   = 1'b1;
                dv_num     = prod_reg[63:0];
                dv_den     = {bs_reg, 16'h0000};
                state_next = ST_F_WAIT;
            end
            ST_F_WAIT:
            begin
                if (!dv_busy_reg)
                    state_next = ent_reg.seen ? ST_WRITE : ST_L2_MUL;
            end
            // bias gradient err/bs
            ST_S_DIV:
            begin
                dv_start   = 1'b1;
                dv_num     = 64'(err_reg);
                dv_den     = {16'h0000, bs_reg};
                state_next = ST_S_WAIT;
            end
            ST_S_WAIT:
            begin
                if (!dv_busy_reg)
                    state_next = ST_WRITE;
            end
            // l2 term -(lambda*w)/(bs*2^16), then mark as touched
            ST_L2_MUL:
            begin
                mul_a      = $signed({2'b00, lambda_reg});
                mul_b      = 33'(ent_reg.w);
                state_next = ST_L2_DIV;
            end
            ST_L2_DIV:
            begin
                dv_start   = 1'b1;
                dv_num     = -prod_reg[63:0];
                dv_den     = {bs_reg, 16'h0000};
                state_next = ST_L2_WAIT;
            end
            ST_L2_WAIT:
            begin
                if (!dv_busy_reg)
                begin
                    tl_we      = mark_ok;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ent_we     = 1'b1;
                state_next = (op_reg == OP_BATCH) ? ST_B_LOAD : ST_IDLE;
            end
            // step size alpha*isqrt((1-p2)*2^16)/(1-p1)
            ST_B_LOAD:
                state_next = ST_B_SQRT;
            ST_B_SQRT:
            begin
                sq_start   = 1'b1;
                sq_in      = {15'h0000, c2, 16'h0000};
                state_next = ST_B_SQWAIT;
            end
            ST_B_SQWAIT:
            begin
                if (!sq_busy_reg)
                    state_next = ST_B_AMUL;
            end
            ST_B_AMUL:
            begin
                mul_a      = $signed({16'h0000, alpha_reg});
                mul_b      = $signed({9'h000, sq_root_reg});
                state_next = ST_B_ADIV;
            end
            ST_B_ADIV:
            begin
                dv_start   = 1'b1;
                dv_num     = prod_reg[63:0];
                dv_den     = {12'h000, c1};
                state_next = ST_B_AWAIT;
            end
            ST_B_AWAIT:
            begin
                if (!dv_busy_reg)
                    state_next = ST_B_NEXT;
            end
            // walk the touched list
            ST_B_NEXT:
                state_next = (k_reg == tc_reg) ? ST_B_P1 : ST_B_FETCH;
            ST_B_FETCH:
            begin
                ent_rd_addr = tl_rd_data;
                state_next  = ST_B_ENTRY;
            end
            ST_B_ENTRY:
                state_next = ST_U_GG;
            ST_U_GG:
            begin
                mul_a      = ag33;
                mul_b      = ag33;
                state_next = ST_U_M1;
            end
            ST_U_M1:
            begin
                mul_a      = $signed({16'h0000, b1});
                mul_b      = 33'(ent_reg.m);
                state_next = ST_U_M2;
            end
            ST_U_M2:
            begin
                mul_a      = $signed({16'h0000, cb1});
                mul_b      = 33'(ent_reg.g);
                state_next = ST_U_V1;
            end
            ST_U_V1:
            begin
                mul_a      = $signed({16'h0000, b2});
                mul_b      = $signed({1'b0, ent_reg.v});
                state_next = ST_U_V2;
            end
            ST_U_V2:
            begin
                mul_a      = $signed({16'h0000, cb2});
                mul_b      = $signed({2'b00, gg_reg[46:16]});
                state_next = ST_U_V3;
            end
            ST_U_V3:
            begin
                mul_a      = $signed({16'h0000, cb2});
                mul_b      = $signed({17'h00000, gg_reg[15:0]});
                state_next = ST_U_V4;
            end
            ST_U_V4:
            begin
                sq_start   = 1'b1;
                sq_in      = {vn, 16'h0000};
                state_next = ST_U_SQWAIT;
            end
            ST_U_SQWAIT:
            begin
                if (!sq_busy_reg)
                    state_next = ST_U_WMUL;
            end
            ST_U_WMUL:
            begin
                mul_a      = 33'(step_reg);
                mul_b      = 33'(ent_reg.m);
                state_next = ST_U_WDIV;
            end
            ST_U_WDIV:
            begin
                dv_start   = 1'b1;
                dv_num     = prod_reg[63:0];
                dv_den     = {4'h0, den_reg};
                state_next = ST_U_WWAIT;
            end
            ST_U_WWAIT:
            begin
                if (!dv_busy_reg)
                    state_next = ST_U_WRITE;
            end
            ST_U_WRITE:
            begin
                ent_we        = 1'b1;
                ent_wr_data   = ent_reg;
                ent_wr_data.g = '0;
                ent_wr_data.seen = 1'b0;
                state_next    = ST_B_NEXT;
            end
            // advance beta powers
            ST_B_P1:
            begin
                mul_a      = $signed({16'h0000, p1_reg});
                mul_b      = $signed({16'h0000, b1});
                state_next = ST_B_P2;
            end
            ST_B_P2:
            begin
                mul_a      = $signed({16'h0000, p2_reg});
                mul_b      = $signed({16'h0000, b2});
                state_next = ST_B_P3;
            end
            ST_B_P3:
                state_next = ST_POST;
            ST_POST:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            tc_reg        <= '0;
            k_reg         <= '0;
            p1_reg        <= '0;
            p2_reg        <= '0;
            loaded_reg    <= 1'b0;
            batch_cnt_reg <= 32'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                    clr_reg <= clr_reg + IDX_W'(1);
                ST_L2_WAIT:
                begin
                    if (!dv_busy_reg && mark_ok)
                        tc_reg <= tc_reg + CNT_W'(1);
                end
                ST_B_LOAD:
                begin
                    if (!loaded_reg)
                    begin
                        p1_reg     <= b1;
                        p2_reg     <= b2;
                        loaded_reg <= 1'b1;
                    end
                end
                ST_B_AWAIT:
                    k_reg <= '0;
                ST_U_WRITE:
                    k_reg <= k_reg + CNT_W'(1);
                ST_B_P2:
                    p1_reg <= prod_reg[32:16];
                ST_B_P3:
                begin
                    p2_reg <= prod_reg[32:16];
                    tc_reg <= '0;
                end
                ST_POST:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        if (op_reg == OP_BATCH)
                            batch_cnt_reg <= batch_cnt_reg + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_reg     <= op_t'(opcode);
                    idx_reg    <= feature_index;
                    idx_ok_reg <= 32'(feature_index) < WEIGHT_COUNT;
                    val_reg    <= feature_value;
                    err_reg    <= err_full[17:0];
                    bs_reg     <= bs_eff;
                    if (opcode == OP_SAMPLE || opcode == OP_BATCH)
                        cur_idx_reg <= IDX_W'(WEIGHT_COUNT - 1);
                    else
                        cur_idx_reg <= IDX_W'(feature_index);
                end
            end
            ST_LATCH:
                ent_reg <= ent_rd_data;
            ST_F_WAIT, ST_S_WAIT:
            begin
                if (!dv_busy_reg)
                    ent_reg.g <= sat_add(ent_reg.g, dv_q);
            end
            ST_L2_WAIT:
            begin
                if (!dv_busy_reg)
                begin
                    ent_reg.g <= sat_add(ent_reg.g, dv_q);
                    if (mark_ok)
                        ent_reg.seen <= 1'b1;
                end
            end
            ST_B_AWAIT:
                step_reg <= dv_q;
            ST_B_FETCH:
                cur_idx_reg <= tl_rd_data;
            ST_B_ENTRY:
                ent_reg <= ent_rd_data;
            ST_U_M1:
                gg_reg <= prod_reg[62:16];
            ST_U_M2:
                acc_reg <= prod_reg;
            ST_U_V1:
                ent_reg.m <= m_new;
            ST_U_V2:
                acc_reg <= prod_reg;
            ST_U_V3:
                acc_reg <= acc_reg + (prod_reg <<< 16);
            ST_U_V4:
                ent_reg.v <= vn;
            ST_U_SQWAIT:
            begin
                if (!sq_busy_reg)
                begin
                    if (({1'b0, sq_root_reg} + {8'h00, eps_reg}) == 25'd0)
                        den_reg <= 25'd1;
                    else
                        den_reg <= {1'b0, sq_root_reg} + {8'h00, eps_reg};
                end
            end
            ST_U_WWAIT:
            begin
                if (!dv_busy_reg)
                    ent_reg.w <= sat_add(ent_reg.w, dv_q);
            end
            ST_POST:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (op_reg == OP_BATCH)
                    begin
                        res_kind_reg <= RES_BATCH;
                        res_idx_reg  <= '0;
                        res_val_reg  <= $signed(batch_cnt_reg);
                    end
                    else
                    begin
                        res_kind_reg <= RES_READ;
                        res_idx_reg  <= idx_reg;
                        res_val_reg  <= idx_ok_reg ? ent_reg.w : 32'sd0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = res_kind_reg;
    assign weight_index = res_idx_reg;
    assign weight_value = res_val_reg;

`ifndef SYNTHESIS
    // no shared unit is still running when a new item is taken
    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!dv_busy_reg && !sq_busy_reg))
        else $error("shared unit busy while idle");

    // touched count never passes the store size
    a_tc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tc_reg <= CNT_W'(WEIGHT_COUNT))
        else $error("touched count overflow");

    // the update walk never passes the touched count
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_B_NEXT) |-> (k_reg <= tc_reg))
        else $error("touched walk overran");

    // beta powers stay within one once loaded
    a_power_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg |-> (p1_reg <= ONE_Q && p2_reg <= ONE_Q))
        else $error("beta power above one");

    // a batch end leaves an empty touched list
    a_batch_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_B_P3) |=> (tc_reg == '0))
        else $error("touched list not cleared");
`endif

endmodule

`default_nettype wire
